// ===== rtl/bod_pkg.sv =====
package bod_pkg;

	// One input byte of the encoded buffer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} byte_item_t;

	// One result item
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] arc_value;
		logic [7:0]  arc_index;
		logic        object_last;
	} arc_item_t;

	// Result kinds
	localparam logic [1:0] KIND_ARC   = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_TRUNC = 2'd2;

	// Commands passed from the front to the back
	typedef enum logic [1:0] {
		OP_ARC   = 2'd0,  // one finished arc in value
		OP_SPLIT = 2'd1,  // first content byte in value[7:0], two arcs
		OP_END   = 2'd2,  // object ended without arc
		OP_TRUNC = 2'd3   // buffer ran out mid-object
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] value;
		logic [7:0]  idx;
		logic        last;
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Arc index counter, saturating at its top value
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		sat_inc = (v == 8'hff) ? v : v + 8'd1;
	endfunction

endpackage

// ===== rtl/ber_oid_stream_decoder.sv =====
// Channel | Direction | Handshake              | Payload
// bytes   | in        | byte_valid, byte_stall | byte_data (data_byte, buffer_end)
// arcs    | out       | arc_valid, arc_stall   | arc_data (kind, arc_value, arc_index,
//         |           |                        |   object_last)
//
// One byte is taken per cycle while the command queue (four entries) has room.
// The output register takes a new result when empty or not stalled; the first
// content byte makes two arcs and so stays at the queue head until both load.
// A result passes a queue slot, then the output register. Reset clears state at once.
// A stall on the arc side fills the queue, after which byte_stall rises.
module ber_oid_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  bod_pkg::byte_item_t byte_data,
	output logic                arc_valid,
	input  logic                arc_stall,
	output bod_pkg::arc_item_t  arc_data
);
	import bod_pkg::*;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head_cmd;

	assign byte_stall = q_full;

	bod_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_data  (byte_data),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	bod_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	bod_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.arc_valid  (arc_valid),
		.arc_stall  (arc_stall),
		.arc_data   (arc_data)
	);

endmodule

// ===== rtl/bod_front.sv =====
module bod_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  bod_pkg::byte_item_t byte_data,
	input  logic                q_full,
	output logic                push,
	output bod_pkg::cmd_t       cmd
);
	import bod_pkg::*;

	typedef enum logic [3:0] {
		PH_LEN   = 4'b0001,
		PH_LBYTE = 4'b0010,
		PH_FIRST = 4'b0100,
		PH_ARCS  = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  left_q, left_n;
	logic [31:0] lacc_q, lacc_n;
	logic [31:0] content_q, content_n;
	logic [31:0] aacc_q, aacc_n;
	logic [7:0]  cnt_q, cnt_n;

	logic [7:0]  b;
	logic        end_in;
	logic        done;
	logic        accept;
	logic        push_c;
	cmd_t        cmd_c;
	logic [31:0] cl_dec;
	logic [31:0] lacc_v;
	logic [31:0] aacc_v;
	logic [3:0]  left_dec;

	assign accept = byte_valid && !q_full;
	assign push   = accept && push_c;
	assign cmd    = cmd_c;

	// Next-state and command decode for one byte
	always_comb begin
		b        = byte_data.data_byte;
		end_in   = byte_data.buffer_end;
		cl_dec   = content_q - 32'd1;
		lacc_v   = {lacc_q[23:0], b};
		aacc_v   = {aacc_q[24:0], b[6:0]};
		left_dec = left_q - 4'd1;

		phase_n   = phase_q;
		left_n    = left_q;
		lacc_n    = lacc_q;
		content_n = content_q;
		aacc_n    = aacc_q;
		cnt_n     = cnt_q;
		done      = 1'b0;
		push_c    = 1'b0;
		cmd_c     = '{op: OP_ARC, value: '0, idx: cnt_q, last: 1'b1};

		case (phase_q)
			PH_LBYTE: begin
				left_n = left_dec;
				lacc_n = lacc_v;
				if (left_dec == 4'd0) begin
					if (lacc_v == 32'd0) begin
						push_c    = 1'b1;
						cmd_c.op  = OP_END;
						done      = 1'b1;
					end else begin
						content_n = lacc_v;
						phase_n   = PH_FIRST;
					end
				end
			end
			PH_FIRST: begin
				content_n = cl_dec;
				if (!(end_in && cl_dec != 32'd0)) begin
					push_c      = 1'b1;
					cmd_c.op    = OP_SPLIT;
					cmd_c.value = {24'd0, b};
					cmd_c.last  = (cl_dec == 32'd0);
					cnt_n       = sat_inc(sat_inc(cnt_q));
					if (cl_dec == 32'd0) begin
						done = 1'b1;
					end else begin
						phase_n = PH_ARCS;
					end
				end
			end
			PH_ARCS: begin
				content_n = cl_dec;
				if (!(end_in && cl_dec != 32'd0)) begin
					if (!b[7]) begin
						push_c      = 1'b1;
						cmd_c.op    = OP_ARC;
						cmd_c.value = aacc_v;
						cmd_c.last  = (cl_dec == 32'd0);
						cnt_n       = sat_inc(cnt_q);
						aacc_n      = '0;
					end else if (cl_dec == 32'd0) begin
						// dangling continuation: partial arc dropped
						push_c   = 1'b1;
						cmd_c.op = OP_END;
					end else begin
						aacc_n = aacc_v;
					end
					if (cl_dec == 32'd0) begin
						done = 1'b1;
					end
				end
			end
			default: begin
				// length octet of a new object; stray codes land here too
				cnt_n     = '0;
				aacc_n    = '0;
				content_n = '0;
				lacc_n    = '0;
				left_n    = '0;
				phase_n   = PH_LEN;
				cmd_c.idx = '0;
				if (!b[7]) begin
					if (b == 8'd0) begin
						push_c   = 1'b1;
						cmd_c.op = OP_END;
					end else begin
						content_n = {24'd0, b};
						phase_n   = PH_FIRST;
					end
				end else if (b[3:0] == 4'd0) begin
					push_c   = 1'b1;
					cmd_c.op = OP_END;
				end else begin
					left_n  = b[3:0];
					phase_n = PH_LBYTE;
				end
			end
		endcase

		// Buffer ran out before the object completed
		if (end_in && !done && phase_n != PH_LEN) begin
			push_c = 1'b1;
			cmd_c  = '{op: OP_TRUNC, value: '0, idx: cnt_n, last: 1'b1};
			done   = 1'b1;
		end

		if (done) begin
			phase_n   = PH_LEN;
			left_n    = '0;
			lacc_n    = '0;
			content_n = '0;
			aacc_n    = '0;
			cnt_n     = '0;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_LEN;
			left_q    <= '0;
			lacc_q    <= '0;
			content_q <= '0;
			aacc_q    <= '0;
			cnt_q     <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			left_q    <= left_n;
			lacc_q    <= lacc_n;
			content_q <= content_n;
			aacc_q    <= aacc_n;
			cnt_q     <= cnt_n;
		end
	end

endmodule

// ===== rtl/bod_queue.sv =====
module bod_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bod_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output bod_pkg::cmd_t head_cmd
);
	import bod_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bod_back.sv =====
module bod_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  bod_pkg::cmd_t      head_cmd,
	output logic               pop,
	output logic               arc_valid,
	input  logic               arc_stall,
	output bod_pkg::arc_item_t arc_data
);
	import bod_pkg::*;

	logic      out_valid_q;
	arc_item_t out_q;
	logic      second_q;
	logic      load;
	arc_item_t res;
	logic      split_first;
	logic [15:0] prod;
	logic [7:0]  quot;
	logic [7:0]  rem;

	assign load        = head_valid && (!out_valid_q || !arc_stall);
	assign split_first = (head_cmd.op == OP_SPLIT) && !second_q;
	assign pop         = load && !split_first;
	assign arc_valid   = out_valid_q;
	assign arc_data    = out_q;

	// Byte / 40 by reciprocal: exact for all 8-bit values
	always_comb begin
		prod = {8'd0, head_cmd.value[7:0]} * 16'd205;
		quot = {5'd0, prod[15:13]};
		rem  = head_cmd.value[7:0] - quot * 8'd40;
	end

	// Expand the head command into a result item
	always_comb begin
		res = '{kind: KIND_ARC, arc_value: '0, arc_index: head_cmd.idx,
			object_last: head_cmd.last};
		case (head_cmd.op)
			OP_ARC: begin
				res.arc_value = head_cmd.value;
			end
			OP_SPLIT: begin
				if (!second_q) begin
					res.arc_value   = {24'd0, quot};
					res.object_last = 1'b0;
				end else begin
					res.arc_value = {24'd0, rem};
					res.arc_index = sat_inc(head_cmd.idx);
				end
			end
			OP_END: begin
				res.kind        = KIND_END;
				res.object_last = 1'b1;
			end
			OP_TRUNC: begin
				res.kind        = KIND_TRUNC;
				res.object_last = 1'b1;
			end
			default: begin
				res.kind = KIND_END;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (!out_valid_q || !arc_stall) begin
				out_valid_q <= head_valid;
			end
			if (load) begin
				second_q <= split_first;
			end
		end
	end

endmodule

// ===== rtl/bod_checker.sv =====
module bod_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                byte_valid,
	input logic                byte_stall,
	input bod_pkg::byte_item_t byte_data,
	input logic                arc_valid,
	input logic                arc_stall,
	input bod_pkg::arc_item_t  arc_data
);
	import bod_pkg::*;

	// A stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("stalled request changed");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arc_valid && arc_stall |=> arc_valid && $stable(arc_data))
		else $error("stalled result changed");

	// End and truncation results always close the object
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		arc_valid && (arc_data.kind == KIND_END || arc_data.kind == KIND_TRUNC)
		|-> arc_data.object_last)
		else $error("end result without object_last");

	// Only arc results carry a value
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		arc_valid && arc_data.kind != KIND_ARC |-> arc_data.arc_value == 32'd0)
		else $error("non-arc result with value");

	// The byte side cannot be held off while no result is pending or queued
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!arc_valid ##1 !arc_valid |-> !byte_stall)
		else $error("byte side stalled with empty output");

endmodule

bind ber_oid_stream_decoder bod_checker u_bod_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.arc_valid  (arc_valid),
	.arc_stall  (arc_stall),
	.arc_data   (arc_data)
);

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bod_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int BYTE_TARGET = 1450;

	// Decoder phases of the predictor
	typedef enum logic [2:0] {
		ST_LENGTH = 3'd0,
		ST_COUNT  = 3'd1,
		ST_FIRST  = 3'd2,
		ST_ARCS   = 3'd3
	} dec_state_t;

	// One queued input byte with its idle gap and an optional drain point
	typedef struct {
		byte_item_t item;
		int         gap;
		bit         drain;
	} pending_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	byte_item_t byte_data = '0;
	logic       arc_valid;
	logic       arc_stall = 1'b0;
	arc_item_t  arc_data;

	ber_oid_stream_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.arc_valid  (arc_valid),
		.arc_stall  (arc_stall),
		.arc_data   (arc_data)
	);

	always #5 clk = ~clk;

	// Predictor state
	dec_state_t  st = ST_LENGTH;
	logic [3:0]  len_left = '0;
	logic [31:0] len_acc = '0;
	logic [31:0] content_left = '0;
	logic [31:0] arc_acc = '0;
	logic [7:0]  arc_cnt = '0;

	pending_byte_t byte_queue [$];
	arc_item_t     arcs_due [$];
	pending_byte_t next_byte;
	arc_item_t     want;

	bit calm = 1'b0;
	bit drain_next = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int flow_left = 0;
	int stall_pick;
	int fails = 0;
	int cycles = 0;
	int n_bytes = 0;
	int n_objects = 0;
	int n_arcs = 0;
	int n_ends = 0;
	int n_truncs = 0;
	int n_sat = 0;

	function automatic void clear_object();
		st = ST_LENGTH;
		len_left = '0;
		len_acc = '0;
		content_left = '0;
		arc_acc = '0;
		arc_cnt = '0;
	endfunction

	function automatic logic [7:0] next_index();
		logic [7:0] idx;
		idx = arc_cnt;
		if (arc_cnt != 8'hff)
			arc_cnt = arc_cnt + 8'd1;
		return idx;
	endfunction

	// Length complete: an empty object ends here, otherwise content follows
	function automatic int open_content(input logic [31:0] len, output arc_item_t r);
		r = '0;
		if (len == 32'd0) begin
			r = '{KIND_END, 32'd0, arc_cnt, 1'b1};
			clear_object();
			return 1;
		end
		content_left = len;
		st = ST_FIRST;
		return 0;
	endfunction

	// Expected results of one accepted byte
	task automatic decode_byte(input byte_item_t it);
		arc_item_t  res [2];
		int         n;
		logic [7:0] b;
		logic [7:0] idx;
		n = 0;
		b = it.data_byte;
		case (st)
			ST_COUNT: begin
				len_acc = {len_acc[23:0], b};
				len_left = len_left - 4'd1;
				if (len_left == 4'd0)
					n = open_content(len_acc, res[0]);
			end
			ST_FIRST: begin
				content_left = content_left - 32'd1;
				if (!it.buffer_end || content_left == 32'd0) begin
					idx = next_index();
					res[0] = '{KIND_ARC, 32'(b / 40), idx, 1'b0};
					idx = next_index();
					res[1] = '{KIND_ARC, 32'(b % 40), idx, content_left == 32'd0};
					n = 2;
					if (content_left == 32'd0)
						clear_object();
					else
						st = ST_ARCS;
				end
			end
			ST_ARCS: begin
				content_left = content_left - 32'd1;
				if (!it.buffer_end || content_left == 32'd0) begin
					arc_acc = {arc_acc[24:0], b[6:0]};
					if (!b[7]) begin
						idx = next_index();
						res[0] = '{KIND_ARC, arc_acc, idx, content_left == 32'd0};
						arc_acc = '0;
						n = 1;
					end else if (content_left == 32'd0) begin
						// continuation bit on the last byte: partial arc is dropped
						res[0] = '{KIND_END, 32'd0, arc_cnt, 1'b1};
						n = 1;
					end
					if (content_left == 32'd0)
						clear_object();
				end
			end
			default: begin
				clear_object();
				if (!b[7]) begin
					n = open_content({24'd0, b}, res[0]);
				end else begin
					// long form: bits 6..4 are don't-care
					len_left = b[3:0];
					len_acc = '0;
					if (len_left == 4'd0)
						n = open_content(32'd0, res[0]);
					else
						st = ST_COUNT;
				end
			end
		endcase
		// buffer ran out mid-object: only the truncation result survives
		if (it.buffer_end && st != ST_LENGTH) begin
			res[0] = '{KIND_TRUNC, 32'd0, arc_cnt, 1'b1};
			n = 1;
			clear_object();
		end
		for (int i = 0; i < n; i++)
			arcs_due.push_back(res[i]);
	endtask

	// Idle gap after a byte: mostly none, sometimes long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic e);
		pending_byte_t p;
		p.item.data_byte = b;
		p.item.buffer_end = e;
		p.gap = draw_gap();
		p.drain = drain_next;
		byte_queue.push_back(p);
		drain_next = 1'b0;
		n_bytes++;
	endtask

	// One object: random first byte and arcs, optional dangling tail, short or
	// long length form; either cut short by buffer_end or sent whole
	task automatic add_object(input int arc_total, input int max_groups, input bit dangle,
			input bit cut, input bit end_last);
		logic [7:0] frame [$];
		logic [7:0] hdr [$];
		int         len, nb, groups, r, pos;
		bit         all_ones;
		frame.push_back(8'($urandom));
		repeat (arc_total) begin
			r = $urandom_range(0, 99);
			groups = r < 50 ? 1 : r < 75 ? 2 : r < 88 ? 3 : r < 95 ? 4 : 5;
			if (groups > max_groups)
				groups = max_groups;
			all_ones = ($urandom_range(0, 9) == 0);
			for (int g = groups - 1; g >= 0; g--)
				frame.push_back({g != 0, all_ones ? 7'h7f : 7'($urandom)});
		end
		if (dangle) begin
			repeat ($urandom_range(1, 2))
				frame.push_back({1'b1, 7'($urandom)});
		end
		len = frame.size();
		if (len < 128 && $urandom_range(0, 2) != 0) begin
			hdr.push_back(8'(len));
		end else begin
			nb = (len > 255) ? 2 : 1;
			r = $urandom_range(0, 9);
			if (r == 0)
				nb = $urandom_range(nb, 15);
			else if (r < 4)
				nb = nb + 1;
			hdr.push_back({1'b1, 3'($urandom), 4'(nb)});
			// count bytes above the low four are shifted out, so any value goes
			for (int i = nb - 1; i >= 0; i--)
				hdr.push_back(i >= 4 ? 8'($urandom) : 8'(len >> (8 * i)));
		end
		frame = {hdr, frame};
		if (cut) begin
			pos = $urandom_range(0, frame.size() - 2);
			for (int i = 0; i <= pos; i++)
				push_byte(frame[i], i == pos);
		end else begin
			foreach (frame[i])
				push_byte(frame[i], end_last && i == frame.size() - 1);
		end
		n_objects++;
	endtask

	// Empty object in one of its encodings
	task automatic add_empty();
		int  nb;
		bit  e;
		e = ($urandom_range(0, 4) == 0);
		case ($urandom_range(0, 2))
			0: push_byte(8'h00, e);
			1: push_byte({1'b1, 3'($urandom), 4'd0}, e);
			default: begin
				nb = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
				push_byte({1'b1, 3'($urandom), 4'(nb)}, 1'b0);
				for (int i = nb - 1; i >= 0; i--)
					push_byte(i >= 4 ? 8'($urandom) : 8'h00, e && i == 0);
			end
		endcase
		n_objects++;
	endtask

	// Random bytes; the last one ends the buffer so the next object starts clean
	task automatic add_noise();
		int k;
		k = $urandom_range(1, 4);
		for (int i = 0; i < k; i++)
			push_byte(8'($urandom), i == k - 1 || $urandom_range(0, 7) == 0);
	endtask

	// Request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_valid && !byte_stall)
				decode_byte(byte_data);
			if (!byte_valid || !byte_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_valid <= 1'b0;
				end else if (byte_queue.size() != 0 &&
						!(byte_queue[0].drain && arcs_due.size() != 0)) begin
					next_byte = byte_queue.pop_front();
					byte_data <= next_byte.item;
					byte_valid <= 1'b1;
					gap_left = next_byte.gap;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and output stall pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (arc_valid && !arc_stall) begin
				if (arcs_due.size() == 0) begin
					if (fails < 10)
						$display("unexpected result: kind %0d value %h index %0d last %0b",
							arc_data.kind, arc_data.arc_value, arc_data.arc_index,
							arc_data.object_last);
					fails++;
				end else begin
					want = arcs_due.pop_front();
					if (arc_data.kind !== want.kind || arc_data.arc_value !== want.arc_value ||
							arc_data.arc_index !== want.arc_index ||
							arc_data.object_last !== want.object_last) begin
						if (fails < 10)
							$display("mismatch: expected kind %0d value %h index %0d last %0b, %s",
								want.kind, want.arc_value, want.arc_index, want.object_last,
								$sformatf("got kind %0d value %h index %0d last %0b",
									arc_data.kind, arc_data.arc_value, arc_data.arc_index,
									arc_data.object_last));
						fails++;
					end
					case (want.kind)
						KIND_ARC:   n_arcs++;
						KIND_END:   n_ends++;
						KIND_TRUNC: n_truncs++;
						default:    ;
					endcase
					if (want.arc_index == 8'hff)
						n_sat++;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				arc_stall <= 1'b1;
			end else if (flow_left > 0) begin
				flow_left--;
				arc_stall <= 1'b0;
			end else begin
				stall_pick = $urandom_range(0, 99);
				if (stall_pick < 45)
					flow_left = $urandom_range(1, 15);
				else if (stall_pick < 55)
					flow_left = $urandom_range(80, 250);
				else if (stall_pick < 88)
					stall_left = $urandom_range(1, 3);
				else if (stall_pick < 97)
					stall_left = $urandom_range(4, 12);
				else
					stall_left = $urandom_range(30, 80);
				arc_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		bit sat_done;
		int r;
		sat_done = 1'b0;

		// directed: empty forms, long-form don't-care bits, first byte extremes,
		// arc overflow, dangling continuation, truncations, length overflow
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hf1, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'hff, 1'b0);
		push_byte(8'h06, 1'b0); push_byte(8'h2b, 1'b0); push_byte(8'h9f, 1'b0);
		push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
		push_byte(8'h7f, 1'b0);
		push_byte(8'h03, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h81, 1'b0);
		push_byte(8'h81, 1'b0);
		push_byte(8'h05, 1'b0); push_byte(8'h2b, 1'b0); push_byte(8'h06, 1'b0);
		push_byte(8'h81, 1'b1);
		push_byte(8'h02, 1'b0); push_byte(8'h2b, 1'b1);
		push_byte(8'h85, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0); push_byte(8'h00, 1'b1);

		// random part, opening with a full drain
		drain_next = 1'b1;
		while (n_bytes < BYTE_TARGET) begin
			if ($urandom_range(0, 40) == 0)
				calm = !calm;
			if ($urandom_range(0, 60) == 0)
				drain_next = 1'b1;
			if (!sat_done && n_bytes > 600) begin
				// enough arcs to pin the index at its top value
				add_object(262, 1, 1'b1, 1'b0, $urandom_range(0, 1));
				sat_done = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60)
					add_object($urandom_range(0, 8), 5, 1'b0, 1'b0, $urandom_range(0, 4) == 0);
				else if (r < 72)
					add_object($urandom_range(0, 8), 5, 1'b0, 1'b1, 1'b0);
				else if (r < 80)
					add_object($urandom_range(0, 4), 5, 1'b1, 1'b0, $urandom_range(0, 3) == 0);
				else if (r < 90)
					add_empty();
				else
					add_noise();
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_queue.size() != 0 || byte_valid)
			@(posedge clk);
		while (arcs_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("summary: %0d bytes in %0d objects plus noise", n_bytes, n_objects);
		$display("summary: %0d arcs, %0d ends without arc, %0d truncations, %0d at index 255",
			n_arcs, n_ends, n_truncs, n_sat);
		if (fails == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
